@@ src/rfld_pkg.sv @@
// Shared types and constants for the load-delay register file.
package rfld_pkg;

  localparam int NumRegsDef   = 32;
  localparam int DataWidthDef = 32;
  localparam int CmdBits      = 3;
  localparam int IdxBits      = 5;
  localparam int ValBits      = 32;
  localparam int OutBits      = 32;

  typedef enum logic [CmdBits-1:0] {
    CmdRead    = 3'd0,
    CmdWrite   = 3'd1,
    CmdLoad    = 3'd2,
    CmdAdvance = 3'd3,
    CmdFlush   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic               en;
    logic [IdxBits-1:0] idx;
  } wr_req_t;

  typedef struct packed {
    logic               en;
    logic               is_read;
    logic [IdxBits-1:0] idx;
  } rd_req_t;

endpackage

@@ src/register_file_load_delay.sv @@
// Top level: general register file with a two-slot load delay.
// An accepted beat's result beat is registered and shows in the next cycle.
// Throughput: one beat per unstalled cycle, set by the bank's single write and
// read port. A new beat is taken while the result register drains in the same
// cycle. Reset (asynchronous, active low) empties both slots and clears the
// bank's valid bits at once, so every register reads zero; no clearing pass.
module register_file_load_delay #(
  parameter int NUM_REGS   = rfld_pkg::NumRegsDef,
  parameter int DATA_WIDTH = rfld_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rfld_pkg::CmdBits-1:0] cmd_i,
  input  logic [rfld_pkg::IdxBits-1:0] reg_index_i,
  input  logic [rfld_pkg::ValBits-1:0] write_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rfld_pkg::OutBits-1:0] read_data_o
);
  import rfld_pkg::*;

  logic                  accept;
  logic                  out_valid_q, out_valid_d;
  logic [IdxBits-1:0]    idx;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  wr_req_t               wr_req;
  rd_req_t               rd_req;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign idx   = (int'(reg_index_i) < NUM_REGS) ? reg_index_i : '0;
  assign value = DATA_WIDTH'(write_value_i);

  assign rd_req.en      = accept;
  assign rd_req.is_read = (cmd_i == CmdRead) && (idx != '0);
  assign rd_req.idx     = idx;

  rfld_slots #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .idx_i    (idx),
    .value_i  (value),
    .wr_req_o (wr_req),
    .wr_data_o(wr_data)
  );

  rfld_bank #(
    .NUM_REGS  (NUM_REGS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_req_i (wr_req),
    .wr_data_i(wr_data),
    .rd_req_i (rd_req),
    .rd_data_o(rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = OutBits'(rd_data);

endmodule

@@ src/rfld_slots.sv @@
// Load delay slots: tracks current and next pending loads and issues bank writes.
module rfld_slots #(
  parameter int DATA_WIDTH = rfld_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [rfld_pkg::CmdBits-1:0] cmd_i,
  input  logic [rfld_pkg::IdxBits-1:0] idx_i,
  input  logic [DATA_WIDTH-1:0]        value_i,
  output rfld_pkg::wr_req_t            wr_req_o,
  output logic [DATA_WIDTH-1:0]        wr_data_o
);
  import rfld_pkg::*;

  logic [IdxBits-1:0]    cur_idx_q, cur_idx_d, next_idx_q, next_idx_d;
  logic [DATA_WIDTH-1:0] cur_val_q, cur_val_d, next_val_q, next_val_d;

  always_comb begin
    cur_idx_d    = cur_idx_q;
    cur_val_d    = cur_val_q;
    next_idx_d   = next_idx_q;
    next_val_d   = next_val_q;
    wr_req_o.en  = 1'b0;
    wr_req_o.idx = idx_i;
    wr_data_o    = value_i;
    if (accept_i) begin
      case (cmd_i)
        CmdWrite: begin
          if (idx_i != '0) begin
            wr_req_o.en = 1'b1;
            if (cur_idx_q == idx_i) cur_idx_d = '0;
          end
        end
        CmdLoad: begin
          if (idx_i != '0) begin
            if (cur_idx_q == idx_i) cur_idx_d = '0;
            next_idx_d = idx_i;
            next_val_d = value_i;
          end
        end
        CmdAdvance: begin
          wr_req_o.en  = (cur_idx_q != '0);
          wr_req_o.idx = cur_idx_q;
          wr_data_o    = cur_val_q;
          cur_idx_d    = next_idx_q;
          cur_val_d    = next_val_q;
          next_idx_d   = '0;
          next_val_d   = '0;
        end
        CmdFlush: begin
          wr_req_o.en  = (cur_idx_q != '0);
          wr_req_o.idx = cur_idx_q;
          wr_data_o    = cur_val_q;
          cur_idx_d    = '0;
          cur_val_d    = '0;
          next_idx_d   = '0;
          next_val_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_idx_q  <= '0;
      cur_val_q  <= '0;
      next_idx_q <= '0;
      next_val_q <= '0;
    end else begin
      cur_idx_q  <= cur_idx_d;
      cur_val_q  <= cur_val_d;
      next_idx_q <= next_idx_d;
      next_val_q <= next_val_d;
    end
  end

endmodule

@@ src/rfld_bank.sv @@
// Register bank: one write port, one registered read port, per-entry valid bits.
module rfld_bank #(
  parameter int NUM_REGS   = rfld_pkg::NumRegsDef,
  parameter int DATA_WIDTH = rfld_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rfld_pkg::wr_req_t     wr_req_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  rfld_pkg::rd_req_t     rd_req_i,
  output logic [DATA_WIDTH-1:0] rd_data_o
);
  import rfld_pkg::*;

  localparam int AddrW = $clog2(NUM_REGS);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   valid_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  rd_hit_q;
  logic [AddrW-1:0]      wr_addr, rd_addr;

  assign wr_addr = AddrW'(wr_req_i.idx);
  assign rd_addr = AddrW'(rd_req_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) mem[wr_addr] <= wr_data_i;
    if (rd_req_i.en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_req_i.en) valid_q[wr_addr] <= 1'b1;
      if (rd_req_i.en) rd_hit_q <= rd_req_i.is_read && valid_q[rd_addr];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule
